// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define GMRM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define GMRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gmrm_pkg.sv -----
`default_nettype none

package gmrm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int MASK_W      = 4;
  localparam int SRC_SLOTS   = 4;
  localparam int SRC_IDX_W   = 2;
  localparam int FLEN_W      = 11;
  localparam int RMS_W       = 15;
  localparam int ROUND_SHIFT = 28;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd960;

  typedef enum logic [2:0] {
    REG_GAIN0,
    REG_GAIN1,
    REG_GAIN2,
    REG_GAIN3,
    REG_MUTE,
    REG_MASTER,
    REG_DEAFEN,
    REG_FLEN
  } reg_idx_t;

  typedef struct packed {
    logic [SRC_SLOTS-1:0][GAIN_W-1:0] gain;
    logic [MASK_W-1:0]                mute;
    logic [GAIN_W-1:0]                master;
    logic                             deafen;
    logic [FLEN_W-1:0]                frame_length;
  } cfg_t;

  typedef struct packed {
    logic                 in_ready;
    logic                 mac;
    logic                 mac_term;
    logic [SRC_IDX_W-1:0] src;
    logic                 master;
    logic                 round;
    logic                 square;
    logic                 accum;
    logic                 div;
    logic                 sqrt_init;
    logic                 sqrt;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/gmrm_in_if.sv -----
`default_nettype none

interface gmrm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gmrm_pkg::SAMPLE_W-1:0] sample_src0;
  logic signed [gmrm_pkg::SAMPLE_W-1:0] sample_src1;
  logic signed [gmrm_pkg::SAMPLE_W-1:0] sample_src2;
  logic signed [gmrm_pkg::SAMPLE_W-1:0] sample_src3;
  logic [gmrm_pkg::MASK_W-1:0]          present_mask;

  modport source (
    output valid, sample_src0, sample_src1, sample_src2, sample_src3, present_mask,
    input  ready
  );

  modport sink (
    input  valid, sample_src0, sample_src1, sample_src2, sample_src3, present_mask,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/gmrm_out_if.sv -----
`default_nettype none

interface gmrm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gmrm_pkg::SAMPLE_W-1:0] mixed_sample;
  logic                                 frame_end;
  logic [gmrm_pkg::RMS_W-1:0]           rms_level;

  modport source (
    output valid, mixed_sample, frame_end, rms_level,
    input  ready
  );

  modport sink (
    input  valid, mixed_sample, frame_end, rms_level,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/gmrm_regs.sv -----
`default_nettype none

module gmrm_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [gmrm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [gmrm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [gmrm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output gmrm_pkg::cfg_t                           cfg
);

  gmrm_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = gmrm_pkg::reg_idx_t'(paddr[gmrm_pkg::APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain         <= {gmrm_pkg::SRC_SLOTS{gmrm_pkg::GAIN_UNITY}};
      cfg.mute         <= '0;
      cfg.master       <= gmrm_pkg::GAIN_UNITY;
      cfg.deafen       <= 1'b0;
      cfg.frame_length <= gmrm_pkg::FLEN_RESET;
    end else if (wr_en) begin
      unique case (idx)
        gmrm_pkg::REG_GAIN0:  cfg.gain[0]      <= pwdata[gmrm_pkg::GAIN_W-1:0];
        gmrm_pkg::REG_GAIN1:  cfg.gain[1]      <= pwdata[gmrm_pkg::GAIN_W-1:0];
        gmrm_pkg::REG_GAIN2:  cfg.gain[2]      <= pwdata[gmrm_pkg::GAIN_W-1:0];
        gmrm_pkg::REG_GAIN3:  cfg.gain[3]      <= pwdata[gmrm_pkg::GAIN_W-1:0];
        gmrm_pkg::REG_MUTE:   cfg.mute         <= pwdata[gmrm_pkg::MASK_W-1:0];
        gmrm_pkg::REG_MASTER: cfg.master       <= pwdata[gmrm_pkg::GAIN_W-1:0];
        gmrm_pkg::REG_DEAFEN: cfg.deafen       <= pwdata[0];
        gmrm_pkg::REG_FLEN:   cfg.frame_length <= pwdata[gmrm_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gmrm_pkg::REG_GAIN0:  prdata = gmrm_pkg::APB_DATA_W'(cfg.gain[0]);
      gmrm_pkg::REG_GAIN1:  prdata = gmrm_pkg::APB_DATA_W'(cfg.gain[1]);
      gmrm_pkg::REG_GAIN2:  prdata = gmrm_pkg::APB_DATA_W'(cfg.gain[2]);
      gmrm_pkg::REG_GAIN3:  prdata = gmrm_pkg::APB_DATA_W'(cfg.gain[3]);
      gmrm_pkg::REG_MUTE:   prdata = gmrm_pkg::APB_DATA_W'(cfg.mute);
      gmrm_pkg::REG_MASTER: prdata = gmrm_pkg::APB_DATA_W'(cfg.master);
      gmrm_pkg::REG_DEAFEN: prdata = gmrm_pkg::APB_DATA_W'(cfg.deafen);
      gmrm_pkg::REG_FLEN:   prdata = gmrm_pkg::APB_DATA_W'(cfg.frame_length);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/gmrm_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

module gmrm_ctrl #(
  parameter int NUM_SOURCES = 4,
  parameter int DIV_STEPS   = 41,
  parameter int SQRT_STEPS  = 21
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gmrm_pkg::sts_t sts,
  output gmrm_pkg::cmd_t      cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_MASTER,
    S_ROUND,
    S_SQUARE,
    S_ACCUM,
    S_DIV,
    S_SQINIT,
    S_SQRT,
    S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sts.in_valid) begin
            state <= S_MAC;
            step  <= '0;
          end
        end
        S_MAC: begin
          if (step == STEP_W'(NUM_SOURCES)) begin
            state <= S_MASTER;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MASTER: state <= S_ROUND;
        S_ROUND:  state <= S_SQUARE;
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM: begin
          if (sts.last) begin
            state <= S_DIV;
            step  <= '0;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_SQINIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SQINIT: begin
          state <= S_SQRT;
          step  <= '0;
        end
        S_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.src      = step[gmrm_pkg::SRC_IDX_W-1:0];
    cmd.in_ready = (state == S_IDLE) && !rst;
    cmd.mac      = (state == S_MAC);
    cmd.mac_term = (state == S_MAC) && (step < STEP_W'(NUM_SOURCES));
    cmd.master   = (state == S_MASTER);
    cmd.round    = (state == S_ROUND);
    cmd.square   = (state == S_SQUARE);
    cmd.accum    = (state == S_ACCUM);
    cmd.div      = (state == S_DIV);
    cmd.sqrt_init = (state == S_SQINIT);
    cmd.sqrt     = (state == S_SQRT);
    cmd.load_out = (state == S_DONE) && sts.out_free;
  end

  `GMRM_ASSERT_IMPL(a_mac_bound, state == S_MAC, step <= STEP_W'(NUM_SOURCES), "source index overrun")
  `GMRM_ASSERT_IMPL(a_sqrt_bound, state == S_SQRT, step < STEP_W'(SQRT_STEPS), "root step overrun")
  `GMRM_ASSERT_NEXT(a_done_hold, state == S_DONE && !sts.out_free, state == S_DONE, "result dropped while stalled")

endmodule

`default_nettype wire

// ----- hdl/gmrm_dp.sv -----
`default_nettype none

`include "assert_macros.svh"

module gmrm_dp #(
  parameter int NUM_SOURCES = 4,
  parameter int MAX_FRAME   = 1024,
  parameter int ACC_W       = 41,
  parameter int RT_W        = 21
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gmrm_pkg::cfg_t cfg,
  input  wire gmrm_pkg::cmd_t cmd,
  output gmrm_pkg::sts_t      sts,
  gmrm_in_if.sink             samples,
  gmrm_out_if.source          results
);

  localparam int SMP_W  = gmrm_pkg::SAMPLE_W;
  localparam int PROD_W = SMP_W + gmrm_pkg::GAIN_W + 1;
  localparam int MIX_W  = PROD_W + $clog2(NUM_SOURCES);
  localparam int TOT_W  = MIX_W + gmrm_pkg::GAIN_W + 1;
  localparam int SQ_W   = 2 * SMP_W - 1;
  localparam int CNT_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int CMP_W  = LEN_W + 1;
  localparam int FLX_W  = gmrm_pkg::FLEN_W + LEN_W;
  localparam int RAD_W  = 2 * RT_W;
  localparam int REM_W  = RT_W + 2;
  localparam int HI_W   = TOT_W - SMP_W + 1;
  localparam logic [TOT_W-1:0] ROUND_BIAS = TOT_W'(1) << (gmrm_pkg::ROUND_SHIFT - 1);
  localparam logic [RT_W-1:0]  RMS_MAX    = RT_W'((1 << gmrm_pkg::RMS_W) - 1);

  logic signed [SMP_W-1:0]           smp [gmrm_pkg::SRC_SLOTS];
  logic [gmrm_pkg::MASK_W-1:0]       prs;
  logic [LEN_W-1:0]                  len;
  logic signed [PROD_W-1:0]          prod;
  logic signed [MIX_W-1:0]           mix;
  logic signed [TOT_W-1:0]           total;
  logic signed [SMP_W-1:0]           outv;
  logic [SQ_W-1:0]                   sq;
  logic [CNT_W-1:0]                  cnt;
  logic [ACC_W-1:0]                  acc;
  logic [ACC_W-1:0]                  dvd;
  logic [LEN_W-1:0]                  rem_d;
  logic [RAD_W-1:0]                  rad;
  logic [REM_W-1:0]                  rem_s;
  logic [RT_W-1:0]                   root;
  logic                              frame_end_r;

  logic                              term_en;
  logic [FLX_W-1:0]                  flx;
  logic [LEN_W-1:0]                  len_next;
  logic signed [TOT_W-1:0]           biased;
  logic signed [TOT_W-1:0]           shifted;
  logic [HI_W-1:0]                   hi;
  logic signed [SMP_W-1:0]           outv_next;
  logic signed [2*SMP_W-1:0]         sq_full;
  logic [ACC_W-1:0]                  acc_sum;
  logic [CMP_W-1:0]                  cnt_inc;
  logic [LEN_W:0]                    rd_t;
  logic [REM_W+1:0]                  rs_t;
  logic [REM_W+1:0]                  trial_s;
  logic [gmrm_pkg::RMS_W-1:0]        rms_val;

  assign samples.ready = cmd.in_ready;
  assign sts.in_valid  = samples.valid;
  assign sts.out_free  = !results.valid || results.ready;

  assign term_en = cmd.mac_term && prs[cmd.src] && !cfg.mute[cmd.src];

  assign flx = FLX_W'(cfg.frame_length);
  always_comb begin
    if (cfg.frame_length == '0) begin
      len_next = LEN_W'(1);
    end else if (flx > FLX_W'(MAX_FRAME)) begin
      len_next = LEN_W'(MAX_FRAME);
    end else begin
      len_next = flx[LEN_W-1:0];
    end
  end

  always_comb begin
    biased  = total + $signed(ROUND_BIAS);
    shifted = biased >>> gmrm_pkg::ROUND_SHIFT;
    hi      = shifted[TOT_W-1:SMP_W-1];
    if (cfg.deafen) begin
      outv_next = '0;
    end else if (hi == '0 || hi == '1) begin
      outv_next = shifted[SMP_W-1:0];
    end else if (shifted[TOT_W-1]) begin
      outv_next = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      outv_next = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  assign sq_full  = outv * outv;
  assign acc_sum  = acc + ACC_W'(sq);
  assign cnt_inc  = CMP_W'(cnt) + CMP_W'(1);
  assign sts.last = (cnt_inc >= CMP_W'(len));

  assign rd_t    = {rem_d, dvd[ACC_W-1]};
  assign rs_t    = {rem_s, rad[RAD_W-1 -: 2]};
  assign trial_s = (REM_W+2)'({root, 2'b01});

  always_comb begin
    if (!frame_end_r || cfg.deafen) begin
      rms_val = '0;
    end else if (root > RMS_MAX) begin
      rms_val = RMS_MAX[gmrm_pkg::RMS_W-1:0];
    end else begin
      rms_val = root[gmrm_pkg::RMS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      acc <= '0;
    end else if (cmd.accum) begin
      cnt <= sts.last ? '0 : cnt_inc[CNT_W-1:0];
      acc <= sts.last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ready && samples.valid) begin
      smp[0] <= samples.sample_src0;
      smp[1] <= samples.sample_src1;
      smp[2] <= samples.sample_src2;
      smp[3] <= samples.sample_src3;
      prs    <= samples.present_mask;
      len    <= len_next;
      prod   <= '0;
      mix    <= '0;
    end
    if (cmd.mac) begin
      prod <= term_en ? smp[cmd.src] * $signed({1'b0, cfg.gain[cmd.src]})
                      : $signed(PROD_W'(0));
      mix  <= mix + MIX_W'(prod);
    end
    if (cmd.master) begin
      total <= mix * $signed({1'b0, cfg.master});
    end
    if (cmd.round) begin
      outv <= outv_next;
    end
    if (cmd.square) begin
      sq <= sq_full[SQ_W-1:0];
    end
    if (cmd.accum) begin
      dvd         <= acc_sum;
      rem_d       <= '0;
      frame_end_r <= sts.last;
    end
    if (cmd.div) begin
      if (rd_t >= (LEN_W+1)'(len)) begin
        rem_d <= LEN_W'(rd_t - (LEN_W+1)'(len));
        dvd   <= {dvd[ACC_W-2:0], 1'b1};
      end else begin
        rem_d <= rd_t[LEN_W-1:0];
        dvd   <= {dvd[ACC_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      rad   <= RAD_W'(dvd);
      rem_s <= '0;
      root  <= '0;
    end
    if (cmd.sqrt) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rs_t >= trial_s) begin
        rem_s <= REM_W'(rs_t - trial_s);
        root  <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem_s <= rs_t[REM_W-1:0];
        root  <= {root[RT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      results.mixed_sample <= outv;
      results.frame_end    <= frame_end_r;
      results.rms_level    <= rms_val;
    end
  end

  `GMRM_ASSERT_NEXT(a_acc_clear, cmd.accum && sts.last, acc == '0 && cnt == '0, "frame state not cleared")
  `GMRM_ASSERT_IMPL(a_rms_masked, results.valid && !results.frame_end, results.rms_level == '0, "level outside frame end")

endmodule

`default_nettype wire

// ----- hdl/gain_mixer_with_rms_meter.sv -----
// Four-source gain mixer with a frame RMS level meter.
// samples: one slot of four Q1.15 samples plus a presence mask, valid/ready.
// results: mixed Q1.15 sample, frame-end flag and frame RMS level, valid/ready.
// Registers sit on the APB port (psel/penable/pwrite/paddr/pwdata, pready tied
// high); write them only while no transaction is in flight.
// Each sample runs through a shared MAC, the master gain multiply,
// rounding/saturation, squaring and accumulation; the next sample is taken
// only after its result has been loaded into the output register.
// A frame-closing sample adds a one-bit-per-cycle divide of the 41-bit square
// sum by the frame length, a setup step and a bit-serial square root.
// A new sample is taken while the previous result still waits at the output
// register; if the receiver stalls longer, the block holds its finished result
// and takes no further sample until the output register is freed.
// Reset restores the register defaults, clears the frame counter and the
// square sum, and empties the output register.
`default_nettype none

module gain_mixer_with_rms_meter #(
  parameter int NUM_SOURCES = 4,
  parameter int MAX_FRAME   = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gmrm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [gmrm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [gmrm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  gmrm_in_if.sink                              samples,
  gmrm_out_if.source                           results
);

  localparam int ACC_W = 2 * gmrm_pkg::SAMPLE_W - 1 + $clog2(MAX_FRAME);
  localparam int RT_W  = (ACC_W + 1) / 2;

  gmrm_pkg::cfg_t cfg;
  gmrm_pkg::cmd_t cmd;
  gmrm_pkg::sts_t sts;

  gmrm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gmrm_ctrl #(
    .NUM_SOURCES (NUM_SOURCES),
    .DIV_STEPS   (ACC_W),
    .SQRT_STEPS  (RT_W)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gmrm_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .MAX_FRAME   (MAX_FRAME),
    .ACC_W       (ACC_W),
    .RT_W        (RT_W)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts),
    .samples (samples),
    .results (results)
  );

endmodule

`default_nettype wire
